// File: rtl/hid_message_segmenter_core_defines.svh
// Assertion macros used by the checker of the HID message segmenter.
`ifndef HID_MESSAGE_SEGMENTER_CORE_DEFINES_SVH
`define HID_MESSAGE_SEGMENTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg
// Types, constants and control codes shared by the HID message segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package hms_pkg;

  // Report geometry and payload limit
  localparam int REPORT_BYTES = 64;
  localparam int MAX_PAYLOAD  = 7609;
  localparam int POS_W        = 6;

  localparam logic [POS_W-1:0] LAST_POS      = POS_W'(REPORT_BYTES - 1);
  localparam logic [POS_W-1:0] INIT_HDR_LAST = POS_W'(6);
  localparam logic [POS_W-1:0] CONT_HDR_LAST = POS_W'(4);
  localparam logic [15:0]      MAX_LEN       = 16'(MAX_PAYLOAD);

  // Header byte positions
  localparam logic [POS_W-1:0] POS_CHAN0  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_CHAN1  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CHAN2  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CHAN3  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CMD    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(5);
  localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(6);

  typedef struct packed {
    logic [31:0] channel_id;
    logic [7:0]  command;
    logic [15:0] message_length;
    logic [7:0]  data_byte;
    logic        has_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       report_byte;
    logic [POS_W-1:0] byte_position;
    logic             end_of_report;
    logic             end_of_message;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_HDR,
    ST_CONT_HDR,
    ST_DATA,
    ST_PAD
  } state_t;

  typedef enum logic [2:0] {
    LATCH_NONE,
    LATCH_DROP,
    LATCH_OVERSIZE,
    LATCH_START,
    LATCH_BYTE
  } latch_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_INIT_HDR,
    EMIT_CONT_HDR,
    EMIT_DATA,
    EMIT_PAD
  } emit_t;

  typedef struct packed {
    latch_t latch;
    emit_t  emit;
  } cmd_t;

  typedef struct packed {
    logic dropping;
    logic active;
    logic in_len_over;
    logic in_has;
    logic off_zero;
    logic off_last;
    logic init_hdr_last;
    logic cont_hdr_last;
    logic rem_one;
    logic len_zero;
    logic has_latched;
    logic emit_ok;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/hms_ctrl.sv
// ----------------------------------------------------------------------------
// hms_ctrl
// Sequencer: takes one request, then walks header, data and pad emission.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire hms_pkg::status_t status,
  output hms_pkg::cmd_t        cmd
);

  hms_pkg::state_t state_r;
  hms_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.latch = hms_pkg::LATCH_NONE;
    cmd.emit  = hms_pkg::EMIT_NONE;
    in_ready  = 1'b0;
    case (state_r)
      hms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.dropping) begin
            cmd.latch = hms_pkg::LATCH_DROP;
          end else if (!status.active && status.in_len_over) begin
            cmd.latch = hms_pkg::LATCH_OVERSIZE;
          end else if (!status.active) begin
            cmd.latch = hms_pkg::LATCH_START;
            state_nxt = hms_pkg::ST_INIT_HDR;
          end else if (status.in_has) begin
            cmd.latch = hms_pkg::LATCH_BYTE;
            state_nxt = status.off_zero ? hms_pkg::ST_CONT_HDR : hms_pkg::ST_DATA;
          end
        end
      end
      hms_pkg::ST_INIT_HDR: begin
        if (status.emit_ok) begin
          cmd.emit = hms_pkg::EMIT_INIT_HDR;
          if (status.init_hdr_last) begin
            if (status.len_zero) begin
              state_nxt = hms_pkg::ST_PAD;
            end else if (status.has_latched) begin
              state_nxt = hms_pkg::ST_DATA;
            end else begin
              state_nxt = hms_pkg::ST_IDLE;
            end
          end
        end
      end
      hms_pkg::ST_CONT_HDR: begin
        if (status.emit_ok) begin
          cmd.emit = hms_pkg::EMIT_CONT_HDR;
          if (status.cont_hdr_last) begin
            state_nxt = hms_pkg::ST_DATA;
          end
        end
      end
      hms_pkg::ST_DATA: begin
        if (status.emit_ok) begin
          cmd.emit = hms_pkg::EMIT_DATA;
          // Pad out the report when the last byte leaves it short
          if (status.rem_one && !status.off_last) begin
            state_nxt = hms_pkg::ST_PAD;
          end else begin
            state_nxt = hms_pkg::ST_IDLE;
          end
        end
      end
      hms_pkg::ST_PAD: begin
        if (status.emit_ok) begin
          cmd.emit = hms_pkg::EMIT_PAD;
          if (status.off_last) begin
            state_nxt = hms_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = hms_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/hms_datapath.sv
// ----------------------------------------------------------------------------
// hms_datapath
// Message state, latched header fields, report byte mux and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hms_pkg::in_item_t in_data,
  input  wire hms_pkg::cmd_t     cmd,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output hms_pkg::out_item_t     out_data,
  output hms_pkg::status_t       status
);

  // Message control state
  logic                        active_r, active_nxt;
  logic                        dropping_r, dropping_nxt;
  logic [15:0]                 rem_r, rem_nxt;
  logic [hms_pkg::POS_W-1:0]   off_r, off_nxt;
  logic [6:0]                  seq_r, seq_nxt;
  logic [31:0]                 chan_r, chan_nxt;
  // Latched payload
  logic [7:0]                  cmd_r, cmd_nxt;
  logic [15:0]                 len_r, len_nxt;
  logic [7:0]                  byte_r, byte_nxt;
  logic                        has_r, has_nxt;
  // Output register
  logic                        out_valid_r, out_valid_nxt;
  hms_pkg::out_item_t          out_data_r, out_data_nxt;

  hms_pkg::out_item_t          emit_item;
  logic [7:0]                  hdr_byte;
  logic                        off_last;
  logic                        emit_ok;
  logic [15:0]                 rem_dec;

  assign off_last = (off_r == hms_pkg::LAST_POS);
  assign emit_ok  = !out_valid_r || out_ready;
  assign rem_dec  = (rem_r == 16'd0) ? 16'd0 : rem_r - 16'd1;

  // Select the header byte for the current position
  always_comb begin
    case (off_r)
      hms_pkg::POS_CHAN0:  hdr_byte = chan_r[7:0];
      hms_pkg::POS_CHAN1:  hdr_byte = chan_r[15:8];
      hms_pkg::POS_CHAN2:  hdr_byte = chan_r[23:16];
      hms_pkg::POS_CHAN3:  hdr_byte = chan_r[31:24];
      hms_pkg::POS_CMD:    hdr_byte = active_r && (len_r != 16'd0) && (cmd.emit ==
                                      hms_pkg::EMIT_CONT_HDR) ? {1'b0, seq_r} : cmd_r;
      hms_pkg::POS_LEN_HI: hdr_byte = len_r[15:8];
      hms_pkg::POS_LEN_LO: hdr_byte = len_r[7:0];
      default:             hdr_byte = 8'd0;
    endcase
  end

  // Next state for latching and emission
  always_comb begin
    active_nxt    = active_r;
    dropping_nxt  = dropping_r;
    rem_nxt       = rem_r;
    off_nxt       = off_r;
    seq_nxt       = seq_r;
    chan_nxt      = chan_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    byte_nxt      = byte_r;
    has_nxt       = has_r;
    emit_item.report_byte    = 8'd0;
    emit_item.byte_position  = off_r;
    emit_item.end_of_report  = 1'b0;
    emit_item.end_of_message = 1'b0;

    case (cmd.latch)
      hms_pkg::LATCH_DROP: begin
        if (in_data.has_byte) begin
          rem_nxt      = rem_dec;
          dropping_nxt = (rem_dec != 16'd0);
        end
      end
      hms_pkg::LATCH_OVERSIZE: begin
        rem_nxt      = in_data.message_length - 16'(in_data.has_byte);
        dropping_nxt = (rem_nxt != 16'd0);
      end
      hms_pkg::LATCH_START: begin
        chan_nxt   = in_data.channel_id;
        cmd_nxt    = in_data.command;
        len_nxt    = in_data.message_length;
        byte_nxt   = in_data.data_byte;
        has_nxt    = in_data.has_byte;
        rem_nxt    = in_data.message_length;
        seq_nxt    = 7'd0;
        off_nxt    = '0;
        active_nxt = 1'b1;
      end
      hms_pkg::LATCH_BYTE: begin
        byte_nxt = in_data.data_byte;
        has_nxt  = in_data.has_byte;
      end
      default: begin
      end
    endcase

    case (cmd.emit)
      hms_pkg::EMIT_INIT_HDR: begin
        emit_item.report_byte = hdr_byte;
        off_nxt = off_r + hms_pkg::POS_W'(1);
      end
      hms_pkg::EMIT_CONT_HDR: begin
        emit_item.report_byte = hdr_byte;
        off_nxt = off_r + hms_pkg::POS_W'(1);
        if (off_r == hms_pkg::CONT_HDR_LAST) begin
          seq_nxt = seq_r + 7'd1;
        end
      end
      hms_pkg::EMIT_DATA: begin
        emit_item.report_byte    = byte_r;
        emit_item.end_of_report  = off_last;
        emit_item.end_of_message = off_last && (rem_r == 16'd1);
        rem_nxt = rem_r - 16'd1;
        off_nxt = off_last ? '0 : off_r + hms_pkg::POS_W'(1);
        if (off_last && (rem_r == 16'd1)) begin
          active_nxt = 1'b0;
        end
      end
      hms_pkg::EMIT_PAD: begin
        emit_item.end_of_report  = off_last;
        emit_item.end_of_message = off_last;
        rem_nxt = 16'd0;
        off_nxt = off_last ? '0 : off_r + hms_pkg::POS_W'(1);
        if (off_last) begin
          active_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Load the output register on emission, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.emit != hms_pkg::EMIT_NONE) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      dropping_r  <= 1'b0;
      rem_r       <= '0;
      off_r       <= '0;
      seq_r       <= '0;
      chan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      dropping_r  <= dropping_nxt;
      rem_r       <= rem_nxt;
      off_r       <= off_nxt;
      seq_r       <= seq_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    len_r      <= len_nxt;
    byte_r     <= byte_nxt;
    has_r      <= has_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to the sequencer
  assign status.dropping      = dropping_r;
  assign status.active        = active_r;
  assign status.in_len_over   = (in_data.message_length > hms_pkg::MAX_LEN);
  assign status.in_has        = in_data.has_byte;
  assign status.off_zero      = (off_r == '0);
  assign status.off_last      = off_last;
  assign status.init_hdr_last = (off_r == hms_pkg::INIT_HDR_LAST);
  assign status.cont_hdr_last = (off_r == hms_pkg::CONT_HDR_LAST);
  assign status.rem_one       = (rem_r == 16'd1);
  assign status.len_zero      = (len_r == 16'd0);
  assign status.has_latched   = has_r;
  assign status.emit_ok       = emit_ok;

endmodule

`default_nettype wire

// File: rtl/hid_message_segmenter_core.sv
// A request is latched into the header and state registers; the first report byte is then
// registered into the output register. Each payload byte is emitted before the next request is
//   taken, with header bytes (7 on an init report, 5 on a continuation) and pad bytes between.
// The single output register is the only emit slot, so a stalled consumer stalls emission.
// Reset (rst_n low, synchronous): idle, no message active, nothing dropping, output empty.
// ----------------------------------------------------------------------------
// hid_message_segmenter_core
// Splits a byte-stream message into fixed-size HID reports, one byte per result.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_message_segmenter_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hms_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hms_pkg::out_item_t     out_data
);

  hms_pkg::cmd_t    cmd;
  hms_pkg::status_t status;

  hms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hms_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

endmodule

`default_nettype wire

// File: rtl/hms_checker.sv
// ----------------------------------------------------------------------------
// hms_checker
// Port-level checks on the report byte stream of the segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hid_message_segmenter_core_defines.svh"

module hms_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire hms_pkg::out_item_t out_data
);

  // Hold a stalled report byte
  `HMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled report byte changed")

  // Message end always closes a report
  `HMS_ASSERT_NOW(a_eom_eor, out_valid && out_data.end_of_message, out_data.end_of_report, "end of message without end of report")

  // Reports are always full size
  `HMS_ASSERT_NOW(a_eor_pos, out_valid && out_data.end_of_report, out_data.byte_position == hms_pkg::LAST_POS, "report ends short")

  // Byte positions advance by one within a report
  `HMS_ASSERT_NEXT(a_pos_step, out_valid && out_ready && !out_data.end_of_report, !out_valid || out_data.byte_position == $past(out_data.byte_position) + 6'd1, "byte position skipped")

endmodule

bind hid_message_segmenter_core hms_checker u_hms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
